>>> src/b52enc_pkg.sv
// Shared types, constants and helpers for the base-52 text encoder.
// Used by b52enc_front, b52enc_back and the top level base52_radix_encoder.
// No dependencies.
package b52enc_pkg;

  // Width of the converted value; bits above it are ignored.
  localparam int VALUE_BITS    = 64;
  localparam int RADIX         = 52;
  localparam int HALF_RADIX    = RADIX / 2;
  localparam int MAX_DIGITS    = 12;
  localparam int DIG_W         = 6;
  localparam int IDX_W         = $clog2(MAX_DIGITS);
  localparam int CNT_W         = $clog2(MAX_DIGITS + 1);
  localparam int BITS_PER_STEP = 4;
  localparam int STEPS         = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PAD_BITS      = STEPS * BITS_PER_STEP;
  localparam int STEP_W        = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int CHAR_W        = 7;
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = 1;
  localparam int QCNT_W        = 2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'd97;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'd65;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  zero;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_out_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_EMIT
  } back_state_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-DIG_W){1'b0}}, d};
    if (dx < CHAR_W'(HALF_RADIX)) begin
      digit_to_ascii = CHAR_LOWER_A + dx;
    end else begin
      digit_to_ascii = CHAR_UPPER_A + (dx - CHAR_W'(HALF_RADIX));
    end
  endfunction

endpackage

>>> src/b52enc_front.sv
// Front end of the encoder: takes transactions, masks and classifies them
// (zero or not) and holds them in a two-entry queue for the back end.
// Depends on b52enc_pkg.
module b52enc_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [63:0]                      in_value,
  input  logic                             pop,
  output b52enc_pkg::q_out_t               q_out
);

  b52enc_pkg::q_item_t                    entry_r [b52enc_pkg::QDEPTH];
  logic [b52enc_pkg::QPTR_W-1:0]          wr_ptr_r, wr_ptr_nxt;
  logic [b52enc_pkg::QPTR_W-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [b52enc_pkg::QCNT_W-1:0]          count_r, count_nxt;
  logic                                   push;
  logic                                   do_pop;
  b52enc_pkg::q_item_t                    new_item;

  assign busy = (count_r == b52enc_pkg::QCNT_W'(b52enc_pkg::QDEPTH));
  assign push = start && !busy;
  assign do_pop = pop && (count_r != '0);

  always_comb begin
    new_item.value = in_value[b52enc_pkg::VALUE_BITS-1:0];
    new_item.zero  = (in_value[b52enc_pkg::VALUE_BITS-1:0] == '0);
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= new_item;
    end
  end

  assign q_out.valid = (count_r != '0);
  assign q_out.item  = entry_r[rd_ptr_r];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= b52enc_pkg::QCNT_W'(b52enc_pkg::QDEPTH))
    else $error("queue count exceeds depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == b52enc_pkg::QCNT_W'(b52enc_pkg::QDEPTH))
      |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

>>> src/b52enc_back.sv
// Back end of the encoder: converts one queued value to base-52 digits with
// a row of doubling cells, four input bits a cycle, then emits the characters.
// Depends on b52enc_pkg.
module b52enc_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  b52enc_pkg::q_out_t                   q_out,
  output logic                                 pop,
  output logic                                 out_valid,
  output logic [b52enc_pkg::CHAR_W-1:0]        out_char_code,
  output logic                                 out_last
);

  b52enc_pkg::back_state_t                   state_r, state_nxt;
  logic [b52enc_pkg::PAD_BITS-1:0]           sh_r, sh_nxt;
  logic [b52enc_pkg::DIG_W-1:0]              cell_r [b52enc_pkg::MAX_DIGITS];
  logic [b52enc_pkg::DIG_W-1:0]              cell_nxt [b52enc_pkg::MAX_DIGITS];
  logic [b52enc_pkg::DIG_W-1:0]              conv_cell [b52enc_pkg::MAX_DIGITS];
  logic [b52enc_pkg::CNT_W-1:0]              n_r, n_nxt, conv_n;
  logic [b52enc_pkg::IDX_W-1:0]              em_r, em_nxt;
  logic [b52enc_pkg::STEP_W-1:0]             step_r, step_nxt;
  logic                                      zero_r, zero_nxt;

  // Each cell holds one base-52 digit. Shifting in a bit doubles the number;
  // a cell at or above half the radix wraps and sends a carry up, and that
  // carry does not depend on the carry coming in, so there is no ripple.
  always_comb begin
    logic [b52enc_pkg::DIG_W:0] dbl;
    logic                       cin;
    logic                       hi;
    for (int i = 0; i < b52enc_pkg::MAX_DIGITS; i++) begin
      conv_cell[i] = cell_r[i];
    end
    for (int k = 0; k < b52enc_pkg::BITS_PER_STEP; k++) begin
      cin = sh_r[b52enc_pkg::PAD_BITS-1-k];
      for (int i = 0; i < b52enc_pkg::MAX_DIGITS; i++) begin
        hi  = (conv_cell[i] >= b52enc_pkg::DIG_W'(b52enc_pkg::HALF_RADIX));
        dbl = {conv_cell[i], cin};
        if (hi) begin
          dbl = dbl - (b52enc_pkg::DIG_W+1)'(b52enc_pkg::RADIX);
        end
        conv_cell[i] = dbl[b52enc_pkg::DIG_W-1:0];
        cin = hi;
      end
    end
  end

  // Multiplying by 16 adds at most one digit, so only the cell just above
  // the current top needs a look.
  always_comb begin
    conv_n = n_r;
    if (n_r < b52enc_pkg::CNT_W'(b52enc_pkg::MAX_DIGITS)) begin
      if (conv_cell[n_r[b52enc_pkg::IDX_W-1:0]] != '0) begin
        conv_n = n_r + 1'b1;
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      b52enc_pkg::BK_IDLE: begin
        if (q_out.valid) begin
          state_nxt = q_out.item.zero ? b52enc_pkg::BK_EMIT : b52enc_pkg::BK_CONV;
        end
      end
      b52enc_pkg::BK_CONV: begin
        if (step_r == '0) begin
          state_nxt = b52enc_pkg::BK_EMIT;
        end
      end
      b52enc_pkg::BK_EMIT: begin
        if (out_last) begin
          state_nxt = b52enc_pkg::BK_IDLE;
        end
      end
      default: state_nxt = b52enc_pkg::BK_IDLE;
    endcase
  end

  // Datapath updates and outputs.
  always_comb begin
    pop      = 1'b0;
    sh_nxt   = sh_r;
    n_nxt    = n_r;
    em_nxt   = em_r;
    step_nxt = step_r;
    zero_nxt = zero_r;
    for (int i = 0; i < b52enc_pkg::MAX_DIGITS; i++) begin
      cell_nxt[i] = cell_r[i];
    end
    out_valid     = 1'b0;
    out_char_code = b52enc_pkg::CHAR_ZERO;
    out_last      = 1'b0;
    case (state_r)
      b52enc_pkg::BK_IDLE: begin
        if (q_out.valid) begin
          pop      = 1'b1;
          sh_nxt   = b52enc_pkg::PAD_BITS'(q_out.item.value);
          zero_nxt = q_out.item.zero;
          n_nxt    = '0;
          em_nxt   = '0;
          step_nxt = b52enc_pkg::STEP_W'(b52enc_pkg::STEPS - 1);
          for (int i = 0; i < b52enc_pkg::MAX_DIGITS; i++) begin
            cell_nxt[i] = '0;
          end
        end
      end
      b52enc_pkg::BK_CONV: begin
        sh_nxt   = sh_r << b52enc_pkg::BITS_PER_STEP;
        step_nxt = step_r - 1'b1;
        n_nxt    = conv_n;
        em_nxt   = b52enc_pkg::IDX_W'(conv_n - 1'b1);
        for (int i = 0; i < b52enc_pkg::MAX_DIGITS; i++) begin
          cell_nxt[i] = conv_cell[i];
        end
      end
      b52enc_pkg::BK_EMIT: begin
        out_valid = 1'b1;
        if (zero_r) begin
          out_char_code = b52enc_pkg::CHAR_ZERO;
          out_last      = 1'b1;
        end else begin
          out_char_code = b52enc_pkg::digit_to_ascii(cell_r[em_r]);
          out_last      = (em_r == '0);
          em_nxt        = em_r - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= b52enc_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    n_r    <= n_nxt;
    em_r   <= em_nxt;
    step_r <= step_nxt;
    zero_r <= zero_nxt;
    for (int i = 0; i < b52enc_pkg::MAX_DIGITS; i++) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  a_chars_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("character stream broken before last");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("strobe continued past last character");

  a_conv_not_zero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == b52enc_pkg::BK_CONV |-> !zero_r)
    else $error("zero value entered conversion");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !zero_r |-> (b52enc_pkg::CNT_W'(em_r) < n_r))
    else $error("emitted digit above the significant digits");

endmodule

>>> src/base52_radix_encoder.sv
// Top level of the base-52 text encoder: front end with queue, back end.
// Depends on b52enc_pkg, b52enc_front and b52enc_back.
//
// Usage:
//   Input: drive in_value and raise start; the transaction is taken at a
//   rising edge where start is high and busy is low. The front end masks
//   the value to its configured width, flags zero and queues it (two deep).
//   Output: each character appears on out_char_code for one cycle with
//   out_valid high; out_last marks the final character of a value. Digits
//   come most significant first, 'a'..'z' then 'A'..'Z'; zero gives '0'.
//   Sequence: the back end takes a value from the queue when it is idle,
//   converts it four input bits a cycle through the digit cells, then
//   emits 1 to 12 characters, most significant first; a zero value skips
//   the conversion and gives one character. The back end takes no new
//   value until the last character of the current one is out. The queue
//   lets two values wait while the back end works.
//   Reset (rst_n low, synchronous) empties the queue and idles the back end.
//   The receiver cannot stall; every strobed character must be taken.
module base52_radix_encoder (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [63:0]                        in_value,
  output logic                               out_valid,
  output logic [b52enc_pkg::CHAR_W-1:0]      out_char_code,
  output logic                               out_last
);

  b52enc_pkg::q_out_t q_out;
  logic               pop;

  b52enc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_value (in_value),
    .pop      (pop),
    .q_out    (q_out)
  );

  b52enc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_out         (q_out),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

endmodule
